// ===== design/gls_pkg.sv =====
// Shared constants, register and command codes, and types of the grid line-of-sight check.
package gls_pkg;

    // Default storage and coordinate sizes.
    localparam int MAP_CELLS_DEF  = 65536;
    localparam int COORD_BITS_DEF = 10;

    // Field widths fixed by the interface.
    localparam int MAP_WIDTH_W  = 11;
    localparam int CELL_COUNT_W = 17;
    localparam int THRESH_W     = 9;
    localparam int COST_W       = 8;
    localparam int CELL_INDEX_W = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 17;

    // Register reset values.
    localparam logic [MAP_WIDTH_W-1:0]  MAP_WIDTH_RST  = 11'd256;
    localparam logic [CELL_COUNT_W-1:0] CELL_COUNT_RST = 17'd65536;
    localparam logic [THRESH_W-1:0]     THRESH_RST     = 9'd253;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd2;

    // Request commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One probed cell handed from the path walker to the cost check.
    typedef struct packed {
        logic valid;
        logic last;
    } gls_probe_t;

endpackage

// ===== design/gls_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module gls_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gls_walker.sv =====
// Four-connected path walker: emits one cell address per cycle from start to end point.
module gls_walker #(
    parameter int COORD_BITS = gls_pkg::COORD_BITS_DEF,
    parameter int ADDR_W     = COORD_BITS + 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            abort,
    input  logic [COORD_BITS-1:0]           x_start,
    input  logic [COORD_BITS-1:0]           y_start,
    input  logic [COORD_BITS-1:0]           x_end,
    input  logic [COORD_BITS-1:0]           y_end,
    input  logic [gls_pkg::MAP_WIDTH_W-1:0] map_width,
    output gls_pkg::gls_probe_t             probe,
    output logic [ADDR_W-1:0]               addr
);
    import gls_pkg::*;

    localparam int CNT_W  = COORD_BITS + 1;
    localparam int ERR_W  = COORD_BITS + 3;
    localparam int PROD_W = MAP_WIDTH_W + COORD_BITS;

    typedef enum logic [2:0] {
        WK_IDLE = 3'b001,
        WK_MUL  = 3'b010,
        WK_STEP = 3'b100
    } wk_state_t;

    wk_state_t                state_reg, state_next;
    logic [COORD_BITS-1:0]    x0_reg, x0_next;
    logic [COORD_BITS-1:0]    y0_reg, y0_next;
    logic [COORD_BITS:0]      dx2_reg, dx2_next;
    logic [COORD_BITS:0]      dy2_reg, dy2_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     x_up_reg, x_up_next;
    logic                     y_up_reg, y_up_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;

    logic [COORD_BITS-1:0]    dx, dy;
    logic [PROD_W-1:0]        row_base;
    logic                     last_cell;

    assign dx = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
    assign dy = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);

    assign row_base  = {{COORD_BITS{1'b0}}, map_width} * {{MAP_WIDTH_W{1'b0}}, y0_reg};
    assign last_cell = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        dx2_next   = dx2_reg;
        dy2_next   = dy2_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        x_up_next  = x_up_reg;
        y_up_next  = y_up_reg;
        addr_next  = addr_reg;
        probe      = '0;

        case (state_reg)
            WK_IDLE:
            begin
                if (start)
                begin
                    x0_next    = x_start;
                    y0_next    = y_start;
                    dx2_next   = {dx, 1'b0};
                    dy2_next   = {dy, 1'b0};
                    err_next   = signed'({3'b000, dx}) - signed'({3'b000, dy});
                    cnt_next   = CNT_W'(dx) + CNT_W'(dy) + CNT_W'(1);
                    x_up_next  = (x_end > x_start);
                    y_up_next  = (y_end > y_start);
                    state_next = WK_MUL;
                end
            end
            WK_MUL:
            begin
                addr_next  = ADDR_W'(x0_reg) + ADDR_W'(row_base);
                state_next = abort ? WK_IDLE : WK_STEP;
            end
            WK_STEP:
            begin
                probe.valid = 1'b1;
                probe.last  = last_cell;
                // A positive error moves along the row, otherwise to the adjacent row.
                if (err_reg > 0)
                begin
                    addr_next = x_up_reg ? (addr_reg + ADDR_W'(1)) : (addr_reg - ADDR_W'(1));
                    err_next  = err_reg - signed'({2'b00, dy2_reg});
                end
                else
                begin
                    addr_next = y_up_reg ? (addr_reg + ADDR_W'(map_width))
                                         : (addr_reg - ADDR_W'(map_width));
                    err_next  = err_reg + signed'({2'b00, dx2_reg});
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_cell || abort)
                begin
                    state_next = WK_IDLE;
                end
            end
            default:
            begin
                state_next = WK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        dx2_reg  <= dx2_next;
        dy2_reg  <= dy2_next;
        err_reg  <= err_next;
        cnt_reg  <= cnt_next;
        x_up_reg <= x_up_next;
        y_up_reg <= y_up_next;
        addr_reg <= addr_next;
    end

    assign addr = addr_reg;

endmodule

// ===== design/grid_line_of_sight_check.sv =====
// Top level of the grid line-of-sight check: map store, path check and handshakes.
//
// Requests arrive on the req channel (req_valid, req_stall driven here). A write word
// (command = write) stores cell_cost at cell_index and gives no response; indexes
// beyond the store are dropped. A query word walks the four-connected path of
// 1 + dx + dy cells between the two points and returns one rsp word with line_clear;
// the walk stops at the first cell that lies outside cell_count or the store, or at or
// above lethal_threshold. The cost store has one read port and the walk reads one cell
// a cycle, so req_stall stays high while a query is in progress; requests are taken one
// at a time. A finished response waits in an output register while rsp_stall is high;
// the next request is accepted meanwhile, and a further result waits until that word is
// taken. Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data while
// the block is idle; the user must keep to this, as the block itself does not enforce
// it. cfg_ready is always high. Reset restores the register defaults and clears the
// state machines and valid flags; the cost store is not cleared, so cells must be
// written before any query walks over them.
module grid_line_of_sight_check #(
    parameter int MAP_CELLS  = gls_pkg::MAP_CELLS_DEF,
    parameter int COORD_BITS = gls_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic                             command,
    input  logic [gls_pkg::CELL_INDEX_W-1:0] cell_index,
    input  logic [gls_pkg::COST_W-1:0]       cell_cost,
    input  logic [COORD_BITS-1:0]            x_start,
    input  logic [COORD_BITS-1:0]            y_start,
    input  logic [COORD_BITS-1:0]            x_end,
    input  logic [COORD_BITS-1:0]            y_end,

    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic                             line_clear,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gls_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gls_pkg::*;

    localparam int MEM_AW = $clog2(MAP_CELLS);
    localparam int ADDR_W = COORD_BITS + 12;
    localparam int CMP_W  = (ADDR_W > 21) ? ADDR_W : 21;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [MAP_WIDTH_W-1:0]  map_width_reg;
    logic [CELL_COUNT_W-1:0] cell_count_reg;
    logic [THRESH_W-1:0]     lethal_threshold_reg;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    line_clear_reg, line_clear_next;
    logic                    result_reg, result_next;

    logic                    chk_valid_reg, chk_valid_next;
    logic                    chk_in_range_reg;
    logic                    chk_last_reg;

    logic                    req_take;
    logic                    walk_start;
    logic                    ram_we;
    logic [CMP_W-1:0]        write_ext;
    logic [CMP_W-1:0]        probe_ext;
    logic                    probe_in_range;
    logic [COST_W-1:0]       rd_cost;
    logic                    blocked;
    logic                    passed;
    logic                    out_free;

    gls_probe_t              probe;
    logic [ADDR_W-1:0]       walk_addr;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign walk_start = req_take && (command == CMD_QUERY);

    assign write_ext = CMP_W'(cell_index);
    assign ram_we    = req_take && (command == CMD_WRITE) && (write_ext < CMP_W'(MAP_CELLS));

    assign probe_ext      = CMP_W'(walk_addr);
    assign probe_in_range = (probe_ext < CMP_W'(cell_count_reg)) &&
                            (probe_ext < CMP_W'(MAP_CELLS));

    gls_walker #(
        .COORD_BITS (COORD_BITS),
        .ADDR_W     (ADDR_W)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (walk_start),
        .abort     (blocked),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .map_width (map_width_reg),
        .probe     (probe),
        .addr      (walk_addr)
    );

    gls_ram #(
        .WIDTH  (COST_W),
        .DEPTH  (MAP_CELLS),
        .ADDR_W (MEM_AW)
    ) u_cost_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_ext[MEM_AW-1:0]),
        .wdata (cell_cost),
        .raddr (probe_ext[MEM_AW-1:0]),
        .rdata (rd_cost)
    );

    // The cost read for a probe returns in the next cycle, together with its range flags.
    assign blocked = chk_valid_reg &&
                     (!chk_in_range_reg || ({1'b0, rd_cost} >= lethal_threshold_reg));
    assign passed  = chk_valid_reg && chk_last_reg && !blocked;

    assign chk_valid_next = probe.valid && !blocked;
    assign out_free       = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        line_clear_next = line_clear_reg;
        result_next     = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (walk_start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (blocked || passed)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next  = 1'b1;
                        line_clear_next = passed;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        result_next = passed;
                        state_next  = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    line_clear_next = result_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            rsp_valid_reg        <= 1'b0;
            chk_valid_reg        <= 1'b0;
            map_width_reg        <= MAP_WIDTH_RST;
            cell_count_reg       <= CELL_COUNT_RST;
            lethal_threshold_reg <= THRESH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            chk_valid_reg <= chk_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:  map_width_reg        <= cfg_data[MAP_WIDTH_W-1:0];
                    REG_CELL_COUNT: cell_count_reg       <= cfg_data[CELL_COUNT_W-1:0];
                    REG_THRESHOLD:  lethal_threshold_reg <= cfg_data[THRESH_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        line_clear_reg   <= line_clear_next;
        result_reg       <= result_next;
        chk_in_range_reg <= probe_in_range;
        chk_last_reg     <= probe.last;
    end

    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign line_clear = line_clear_reg;

    a_query_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        walk_start |=> (state_reg == ST_WALK))
        else $error("accepted query did not start a walk");

    a_probe_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        probe.valid |-> (state_reg == ST_WALK))
        else $error("walker probed a cell outside a query");

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("cost store written during a walk");

    a_check_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == ST_WALK))
        else $error("cost check pending outside a query");

endmodule
